// ===== src/dep_pkg.sv =====
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants
// Node count, balance width, item structs and the balance store request.
// ----------------------------------------------------------------------------
`default_nettype none

package dep_pkg;

    localparam int NODE_COUNT   = 26;
    localparam int BAL_WIDTH    = 18;
    localparam int LETTER_WIDTH = 5;
    localparam int NODE_IW      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    typedef logic [NODE_COUNT-1:0]       t_nodes;
    typedef logic [NODE_IW-1:0]          t_idx;
    typedef logic signed [BAL_WIDTH-1:0] t_bal;

    localparam t_bal BAL_ZERO    = '0;
    localparam t_bal BAL_ONE     = t_bal'(1);
    localparam t_bal BAL_NEG_ONE = '1;
    localparam t_bal BAL_MAX     = {1'b0, {(BAL_WIDTH-1){1'b1}}};
    localparam t_bal BAL_MIN     = {1'b1, {(BAL_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [LETTER_WIDTH-1:0] start_letter;
        logic [LETTER_WIDTH-1:0] end_letter;
        logic                    last_word;
    } t_in_item;

    typedef struct packed {
        logic possible;
        logic overflow;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        t_idx wr_addr;
        t_bal wr_data;
        t_idx rd_addr;
        logic clear;
    } t_bal_req;

endpackage

`default_nettype wire

// ===== src/directed_euler_path_check_top.sv =====
// ----------------------------------------------------------------------------
// directed_euler_path_check_top: Euler trail existence check on a word set
// Loads words as directed edges and rules on the set after its last word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one word per item: start letter,
//   end letter and a last-word mark. Output channel o_valid/i_ready carries
//   one verdict (possible, overflow) per set, after the word marked last.
//   A word that moves a balance takes two read/update steps of the single
//   saturating adder on the balance memory port; a self loop, an
//   out-of-range word or a word without balance change skips them.
//   The check after the last word runs the balance scan, then the seed,
//   then reachability passes over the adjacency rows; passes repeat
//   until the reached set stops growing (at most NODE_COUNT passes),
//   then hands the verdict to the output register.
//   The output register lets the next set load while a verdict waits; a
//   verdict only stalls the block when the previous one was not yet taken.
//   Reset clears all matrix rows, balances, marks and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_euler_path_check_top
    import dep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_S    = 4'd1;
    localparam logic [3:0] ST_UP_S    = 4'd2;
    localparam logic [3:0] ST_UP_E    = 4'd3;
    localparam logic [3:0] ST_BAL     = 4'd4;
    localparam logic [3:0] ST_BAL_END = 4'd5;
    localparam logic [3:0] ST_SEED    = 4'd6;
    localparam logic [3:0] ST_REACH   = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam t_idx LAST_IDX = t_idx'(NODE_COUNT - 1);

    logic [3:0] r_state, n_state;
    t_idx       r_s, n_s, r_e, n_e, r_idx, n_idx;
    logic       r_last, n_last;
    t_nodes     r_adj [NODE_COUNT];
    t_nodes     n_adj [NODE_COUNT];
    t_nodes     r_used, n_used, r_reach, n_reach, r_prev, n_prev;
    logic       r_ovf, n_ovf, r_bad, n_bad, r_plus, n_plus, r_minus, n_minus;
    logic       r_pend, n_pend, r_conn, n_conn;
    logic       r_ovalid, n_ovalid;
    t_out_item  r_odata, n_odata;

    t_bal_req   bal_req;
    t_bal       bal_rd;
    t_bal       sat_value;
    logic       sat_hit;
    logic       accept, in_range, fire;
    t_idx       in_s, in_e;
    t_nodes     row, idx_bit, step_reach;

    dep_bal_store u_bal_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (bal_req),
        .o_rd_data (bal_rd)
    );

    dep_sat_step u_sat_step (
        .i_value (bal_rd),
        .i_dec   (r_state == ST_UP_E),
        .o_value (sat_value),
        .o_sat   (sat_hit)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    assign accept   = i_valid && o_ready;
    assign in_range = (32'(i_data.start_letter) < 32'(NODE_COUNT))
                   && (32'(i_data.end_letter) < 32'(NODE_COUNT));
    assign in_s     = t_idx'(i_data.start_letter);
    assign in_e     = t_idx'(i_data.end_letter);
    assign fire     = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    assign row     = r_adj[r_idx];
    assign idx_bit = t_nodes'(1) << r_idx;

    always_comb begin
        if ((r_reach & idx_bit) != '0) begin
            step_reach = r_reach | row;
        end else if ((row & r_prev) != '0) begin
            step_reach = r_reach | idx_bit;
        end else begin
            step_reach = r_reach;
        end
    end

    always_comb begin
        bal_req.wr_en   = (r_state == ST_UP_S) || (r_state == ST_UP_E);
        bal_req.wr_addr = (r_state == ST_UP_S) ? r_s : r_e;
        bal_req.wr_data = sat_value;
        bal_req.clear   = fire;
        case (r_state)
            ST_RD_S: bal_req.rd_addr = r_s;
            ST_UP_S: bal_req.rd_addr = r_e;
            default: bal_req.rd_addr = r_idx;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_e      = r_e;
        n_idx    = r_idx;
        n_last   = r_last;
        n_adj    = r_adj;
        n_used   = r_used;
        n_reach  = r_reach;
        n_prev   = r_prev;
        n_ovf    = r_ovf;
        n_bad    = r_bad;
        n_plus   = r_plus;
        n_minus  = r_minus;
        n_pend   = (r_state == ST_BAL);
        n_conn   = r_conn;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;

        // evaluate the balance read issued in the previous cycle
        if (r_pend) begin
            if (bal_rd == BAL_ONE) begin
                n_bad  = r_bad || r_plus;
                n_plus = 1'b1;
            end else if (bal_rd == BAL_NEG_ONE) begin
                n_bad   = r_bad || r_minus;
                n_minus = 1'b1;
            end else if (bal_rd != BAL_ZERO) begin
                n_bad = 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_s    = in_s;
                    n_e    = in_e;
                    n_last = i_data.last_word;
                    n_idx  = '0;
                    if (in_range) begin
                        n_adj[in_s] = r_adj[in_s] | (t_nodes'(1) << in_e);
                        n_used      = r_used | (t_nodes'(1) << in_s) | (t_nodes'(1) << in_e);
                    end
                    if (in_range && (in_s != in_e)) begin
                        n_state = ST_RD_S;
                    end else if (i_data.last_word) begin
                        n_state = ST_BAL;
                    end
                end
            end
            ST_RD_S: begin
                n_state = ST_UP_S;
            end
            ST_UP_S: begin
                n_ovf   = r_ovf || sat_hit;
                n_state = ST_UP_E;
            end
            ST_UP_E: begin
                n_ovf   = r_ovf || sat_hit;
                n_state = r_last ? ST_BAL : ST_IDLE;
            end
            ST_BAL: begin
                n_idx = r_idx + t_idx'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_BAL_END;
                end
            end
            ST_BAL_END: begin
                n_state = ST_SEED;
            end
            ST_SEED: begin
                n_idx = '0;
                if (r_used == '0) begin
                    n_conn  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_reach = r_used & (~r_used + t_nodes'(1));
                    n_prev  = r_used & (~r_used + t_nodes'(1));
                    n_state = ST_REACH;
                end
            end
            ST_REACH: begin
                n_reach = step_reach;
                n_idx   = r_idx + t_idx'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    if (step_reach == r_prev) begin
                        n_conn  = (r_used & ~step_reach) == '0;
                        n_state = ST_DONE;
                    end else begin
                        n_prev = step_reach;
                    end
                end
            end
            ST_DONE: begin
                if (fire) begin
                    n_ovalid         = 1'b1;
                    n_odata.possible = r_conn && !r_bad && !r_ovf;
                    n_odata.overflow = r_ovf;
                    for (int i = 0; i < NODE_COUNT; i++) begin
                        n_adj[i] = '0;
                    end
                    n_used  = '0;
                    n_reach = '0;
                    n_prev  = '0;
                    n_ovf   = 1'b0;
                    n_bad   = 1'b0;
                    n_plus  = 1'b0;
                    n_minus = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_e     <= n_e;
        r_last  <= n_last;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_adj[i] <= '0;
            end
            r_used   <= '0;
            r_reach  <= '0;
            r_prev   <= '0;
            r_ovf    <= 1'b0;
            r_bad    <= 1'b0;
            r_plus   <= 1'b0;
            r_minus  <= 1'b0;
            r_pend   <= 1'b0;
            r_conn   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_adj    <= n_adj;
            r_used   <= n_used;
            r_reach  <= n_reach;
            r_prev   <= n_prev;
            r_ovf    <= n_ovf;
            r_bad    <= n_bad;
            r_plus   <= n_plus;
            r_minus  <= n_minus;
            r_pend   <= n_pend;
            r_conn   <= n_conn;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

`default_nettype wire

// ===== src/dep_sat_step.sv =====
// ----------------------------------------------------------------------------
// dep_sat_step: shared saturating balance step
// Adds +1 or -1 to a balance and clamps at the signed limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_sat_step
    import dep_pkg::*;
(
    input  t_bal i_value,
    input  logic i_dec,
    output t_bal o_value,
    output logic o_sat
);

    logic [BAL_WIDTH:0] sum;

    assign sum = {i_value[BAL_WIDTH-1], i_value}
               + (i_dec ? {(BAL_WIDTH+1){1'b1}} : (BAL_WIDTH+1)'(1));

    assign o_sat   = sum[BAL_WIDTH] != sum[BAL_WIDTH-1];
    assign o_value = o_sat ? (i_dec ? BAL_MIN : BAL_MAX) : t_bal'(sum[BAL_WIDTH-1:0]);

endmodule

`default_nettype wire

// ===== src/dep_bal_store.sv =====
// ----------------------------------------------------------------------------
// dep_bal_store: per-node balance memory
// One write and one registered read per cycle; entries whose valid bit is clear read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_bal_store
    import dep_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bal_req i_req,
    output t_bal     o_rd_data
);

    t_bal   r_mem [NODE_COUNT];
    t_bal   r_rd_raw;
    logic   r_rd_vld;
    t_nodes r_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_raw <= r_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_req.rd_addr];
            if (i_req.clear) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : BAL_ZERO;

endmodule

`default_nettype wire

// ===== src/dep_checker.sv =====
// ----------------------------------------------------------------------------
// dep_checker: port-level checks for the Euler trail checker
// Watches both channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_checker
    import dep_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_item  i_data,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output item dropped or changed while stalled");

    a_ovf_not_possible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.overflow && o_data.possible))
        else $error("overflowed set reported as possible");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.last_word |=> !o_ready)
        else $error("ready right after a last word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind directed_euler_path_check_top dep_checker u_dep_checker (.*);

`default_nettype wire
